// File: src/fftbf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the build-time twiddle function for the
// radix-2 butterfly stage. No dependencies.
package fftbf_pkg;

    localparam int FFT_POINTS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int RESULT_W = 33;
    localparam int SUM_W    = 35;

    localparam real PI = 3.14159265358979323846;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] im;
        logic signed [SAMPLE_W-1:0] re;
    } twiddle_t;

    typedef struct packed {
        logic step;
        logic last;
    } tw_adv_t;

    function automatic logic [SAMPLE_W-1:0] q_round(input real v);
        real m;
        real r;
        int  q;
        m = (v < 0.0) ? -v : v;
        r = $floor(m + 0.5);
        if (r > 65536.0)
        begin
            r = 65536.0;
        end
        q = $rtoi(r);
        if (v < 0.0)
        begin
            q = -q;
        end
        if (q > SAMPLE_MAX)
        begin
            q = SAMPLE_MAX;
        end
        if (q < SAMPLE_MIN)
        begin
            q = SAMPLE_MIN;
        end
        return SAMPLE_W'(q);
    endfunction

    // step is the angle between neighboring entries, 2*pi/N
    function automatic twiddle_t make_twiddle(input int k, input real step, input int frac);
        real      x;
        real      scale;
        twiddle_t w;
        x     = step * real'(k);
        scale = 2.0 ** frac;
        w.re  = q_round($cos(x) * scale);
        w.im  = q_round(-$sin(x) * scale);
        return w;
    endfunction

endpackage

// File: src/fftbf_pair_if.sv
`timescale 1ns / 1ps
// Input channel: one butterfly pair per beat (a, b complex and last flag).
// Depends on fftbf_pkg.
interface fftbf_pair_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   last_in;
    logic signed [fftbf_pkg::SAMPLE_W-1:0]  a_re;
    logic signed [fftbf_pkg::SAMPLE_W-1:0]  a_im;
    logic signed [fftbf_pkg::SAMPLE_W-1:0]  b_re;
    logic signed [fftbf_pkg::SAMPLE_W-1:0]  b_im;

    modport source (output valid, last_in, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, last_in, a_re, a_im, b_re, b_im, output ready);
endinterface

// File: src/fftbf_result_if.sv
`timescale 1ns / 1ps
// Output channel: sum and difference of one butterfly per beat.
// Depends on fftbf_pkg.
interface fftbf_result_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   last_out;
    logic signed [fftbf_pkg::RESULT_W-1:0]  sum_re;
    logic signed [fftbf_pkg::RESULT_W-1:0]  sum_im;
    logic signed [fftbf_pkg::RESULT_W-1:0]  diff_re;
    logic signed [fftbf_pkg::RESULT_W-1:0]  diff_im;

    modport source (output valid, last_out, sum_re, sum_im, diff_re, diff_im, input ready);
    modport sink   (input valid, last_out, sum_re, sum_im, diff_re, diff_im, output ready);
endinterface

// File: src/radix2_fft_butterfly_stage.sv
`timescale 1ns / 1ps
// Radix-2 DIT butterfly stage: input register, then products and sums, then result register.
// A pair passes the input register, then the result register; one pair per cycle unless bfly stalls.
// Each stage holds its own valid bit, so a stalled output still lets a bubble fill.
// Reset clears the stage valids, the twiddle pointer, and reloads twiddle entry 0.
// Depends on fftbf_pkg, fftbf_pair_if, fftbf_result_if, fftbf_twiddle.
module radix2_fft_butterfly_stage #(
    parameter int FFT_POINTS = fftbf_pkg::FFT_POINTS_DEF,
    parameter int FRAC_BITS  = fftbf_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    fftbf_pair_if.sink     pair,
    fftbf_result_if.source bfly
);

    localparam int SW = fftbf_pkg::SAMPLE_W;
    localparam int PW = fftbf_pkg::PROD_W;
    localparam int UW = fftbf_pkg::SUM_W;
    localparam int RW = fftbf_pkg::RESULT_W;

    fftbf_pkg::tw_adv_t  adv;
    fftbf_pkg::twiddle_t tw;

    logic en_a;
    logic en_c;
    logic take;

    logic                 va_reg;
    logic                 last_a_reg;
    logic signed [SW-1:0] ar_a_reg;
    logic signed [SW-1:0] ai_a_reg;
    logic signed [SW-1:0] br_a_reg;
    logic signed [SW-1:0] bi_a_reg;
    fftbf_pkg::twiddle_t  w_a_reg;

    logic                 vc_reg;
    logic                 last_c_reg;
    logic signed [RW-1:0] sum_re_reg;
    logic signed [RW-1:0] sum_im_reg;
    logic signed [RW-1:0] diff_re_reg;
    logic signed [RW-1:0] diff_im_reg;

    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
    logic signed [UW-1:0] prod_re;
    logic signed [UW-1:0] prod_im;
    logic signed [UW-1:0] scl_re;
    logic signed [UW-1:0] scl_im;
    logic signed [UW-1:0] sum_re_next;
    logic signed [UW-1:0] sum_im_next;
    logic signed [UW-1:0] diff_re_next;
    logic signed [UW-1:0] diff_im_next;

    assign en_c = !vc_reg || bfly.ready;
    assign en_a = !va_reg || en_c;
    assign take = pair.valid && en_a;

    assign pair.ready = en_a;
    assign adv.step   = take;
    assign adv.last   = pair.last_in;

    fftbf_twiddle #(
        .FFT_POINTS (FFT_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_twiddle (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .tw    (tw)
    );

    always_comb
    begin
        p_rr         = PW'(br_a_reg * w_a_reg.re);
        p_ii         = PW'(bi_a_reg * w_a_reg.im);
        p_ri         = PW'(br_a_reg * w_a_reg.im);
        p_ir         = PW'(bi_a_reg * w_a_reg.re);
        prod_re      = UW'(p_rr) - UW'(p_ii);
        prod_im      = UW'(p_ri) + UW'(p_ir);
        scl_re       = UW'(ar_a_reg) <<< FRAC_BITS;
        scl_im       = UW'(ai_a_reg) <<< FRAC_BITS;
        sum_re_next  = scl_re + prod_re;
        sum_im_next  = scl_im + prod_im;
        diff_re_next = scl_re - prod_re;
        diff_im_next = scl_im - prod_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                va_reg <= pair.valid;
            end
            if (en_c)
            begin
                vc_reg <= va_reg;
            end
        end
    end

    // capture the beat with the twiddle prefetched for it
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            last_a_reg <= pair.last_in;
            ar_a_reg   <= pair.a_re;
            ai_a_reg   <= pair.a_im;
            br_a_reg   <= pair.b_re;
            bi_a_reg   <= pair.b_im;
            w_a_reg    <= tw;
        end
        if (en_c && va_reg)
        begin
            last_c_reg  <= last_a_reg;
            sum_re_reg  <= sum_re_next[RW-1:0];
            sum_im_reg  <= sum_im_next[RW-1:0];
            diff_re_reg <= diff_re_next[RW-1:0];
            diff_im_reg <= diff_im_next[RW-1:0];
        end
    end

    assign bfly.valid    = vc_reg;
    assign bfly.last_out = last_c_reg;
    assign bfly.sum_re   = sum_re_reg;
    assign bfly.sum_im   = sum_im_reg;
    assign bfly.diff_re  = diff_re_reg;
    assign bfly.diff_im  = diff_im_reg;

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !va_reg && !vc_reg |-> pair.ready)
        else $error("empty pipeline refuses a pair");

    a_drain_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        bfly.valid && bfly.ready && !va_reg |=> !bfly.valid)
        else $error("result repeated after drain");

    a_stage_a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg && !en_c |=> va_reg && $stable(last_a_reg) && $stable(w_a_reg))
        else $error("input stage lost a held pair");

endmodule

// File: src/fftbf_twiddle.sv
`timescale 1ns / 1ps
// Twiddle pointer and prefetched twiddle register over a build-time ROM.
// Depends on fftbf_pkg.
module fftbf_twiddle #(
    parameter int FFT_POINTS = fftbf_pkg::FFT_POINTS_DEF,
    parameter int FRAC_BITS  = fftbf_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fftbf_pkg::tw_adv_t  adv,
    output fftbf_pkg::twiddle_t tw
);

    localparam int  TW_COUNT = FFT_POINTS / 2;
    localparam int  PTR_W    = (TW_COUNT > 1) ? $clog2(TW_COUNT) : 1;
    localparam real TW_STEP  = 2.0 * fftbf_pkg::PI / real'(FFT_POINTS);
    localparam fftbf_pkg::twiddle_t TW_ZERO = fftbf_pkg::make_twiddle(0, TW_STEP, FRAC_BITS);

    fftbf_pkg::twiddle_t rom [TW_COUNT];

    for (genvar k = 0; k < TW_COUNT; k++)
    begin : g_rom
        localparam fftbf_pkg::twiddle_t W = fftbf_pkg::make_twiddle(k, TW_STEP, FRAC_BITS);
        assign rom[k] = W;
    end

    logic [PTR_W-1:0]    ptr_reg;
    logic [PTR_W-1:0]    ptr_next;
    fftbf_pkg::twiddle_t tw_reg;
    fftbf_pkg::twiddle_t tw_next;

    always_comb
    begin
        ptr_next = ptr_reg;
        if (adv.step)
        begin
            if (adv.last || ptr_reg == PTR_W'(TW_COUNT - 1))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
        tw_next = rom[ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            tw_reg  <= TW_ZERO;
        end
        else
        begin
            ptr_reg <= ptr_next;
            tw_reg  <= tw_next;
        end
    end

    assign tw = tw_reg;

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        adv.step && adv.last |=> ptr_reg == '0)
        else $error("twiddle pointer not cleared after last pair");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !adv.step |=> $stable(ptr_reg) && $stable(tw_reg))
        else $error("twiddle state moved without a pair");

    a_tw_matches: assert property (@(posedge clk) disable iff (!rst_n)
        tw_reg == rom[ptr_reg])
        else $error("prefetched twiddle does not match pointer");

endmodule
